// File: hdl/integral_image_stream_core_defines.svh
// Assertion macros shared by the integral image stream core.
`ifndef INTEGRAL_IMAGE_STREAM_CORE_DEFINES_SVH
`define INTEGRAL_IMAGE_STREAM_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define IIS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IIS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define IIS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/iis_pkg.sv
// Types and constants shared by the integral image stream core.
package iis_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIXEL_BITS  = 8;
    localparam int SIZE_BITS   = 11;
    localparam int SUM_BITS    = 28;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int ROWSUM_BITS = PIXEL_BITS + COL_BITS;
    localparam int FIFO_DEPTH  = 2;
    localparam int REG_BITS    = 1;

    localparam logic [REG_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);

    typedef struct packed {
        logic [ROWSUM_BITS-1:0] row_sum;
        logic [COL_BITS-1:0]    col;
        logic                   top_row;
        logic                   row_last;
        logic                   plane_last;
    } t_item;
endpackage

// File: hdl/iis_front.sv
// Front end: accepts pixels, tracks row and column, keeps the row running sum.
`include "integral_image_stream_core_defines.svh"
module iis_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [iis_pkg::SIZE_BITS-1:0]      i_image_width,
    input  logic [iis_pkg::SIZE_BITS-1:0]      i_image_height,
    input  logic                               i_valid,
    input  logic [iis_pkg::PIXEL_BITS-1:0]     i_pixel,
    input  logic                               i_queue_full,
    output logic                               o_ready,
    output logic                               o_push,
    output iis_pkg::t_item                     o_push_item
);
    logic [iis_pkg::COL_BITS-1:0]    r_col, n_col;
    logic [iis_pkg::ROW_BITS-1:0]    r_row, n_row;
    logic [iis_pkg::ROWSUM_BITS-1:0] r_row_sum, n_row_sum;
    logic [iis_pkg::SIZE_BITS-1:0]   w_width, w_height;
    logic [iis_pkg::COL_BITS-1:0]    w_last_col;
    logic [iis_pkg::ROW_BITS-1:0]    w_last_row;
    logic [iis_pkg::ROWSUM_BITS-1:0] w_sum;
    logic                            w_accept, w_end_row, w_end_plane;

    // Zero acts as one, anything above the maximum acts as the maximum.
    always_comb begin
        if (i_image_width == '0) begin
            w_width = iis_pkg::SIZE_BITS'(1);
        end else if (i_image_width > iis_pkg::SIZE_BITS'(iis_pkg::MAX_WIDTH)) begin
            w_width = iis_pkg::SIZE_BITS'(iis_pkg::MAX_WIDTH);
        end else begin
            w_width = i_image_width;
        end
        if (i_image_height == '0) begin
            w_height = iis_pkg::SIZE_BITS'(1);
        end else if (i_image_height > iis_pkg::SIZE_BITS'(iis_pkg::MAX_HEIGHT)) begin
            w_height = iis_pkg::SIZE_BITS'(iis_pkg::MAX_HEIGHT);
        end else begin
            w_height = i_image_height;
        end
    end

    assign w_last_col  = iis_pkg::COL_BITS'(w_width - iis_pkg::SIZE_BITS'(1));
    assign w_last_row  = iis_pkg::ROW_BITS'(w_height - iis_pkg::SIZE_BITS'(1));
    assign w_end_row   = (r_col >= w_last_col);
    assign w_end_plane = w_end_row && (r_row >= w_last_row);
    assign w_sum       = r_row_sum + iis_pkg::ROWSUM_BITS'(i_pixel);
    assign o_ready     = !i_queue_full;
    assign w_accept    = i_valid && o_ready;
    assign o_push      = w_accept;

    always_comb begin
        o_push_item.row_sum    = w_sum;
        o_push_item.col        = r_col;
        o_push_item.top_row    = (r_row == '0);
        o_push_item.row_last   = w_end_row;
        o_push_item.plane_last = w_end_plane;
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_row_sum = r_row_sum;
        if (w_accept) begin
            if (w_end_row) begin
                n_col     = '0;
                n_row_sum = '0;
                n_row     = w_end_plane ? '0 : r_row + 1'b1;
            end else begin
                n_col     = r_col + 1'b1;
                n_row_sum = w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_row_sum <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_row_sum <= n_row_sum;
        end
    end

    `IIS_ASSERT(a_row_restart, i_clk, i_rst_n, w_accept && w_end_row |=> r_col == '0 && r_row_sum == '0, "row end did not restart column and row sum")
    `IIS_ASSERT(a_idle_hold, i_clk, i_rst_n, !w_accept |=> $stable(r_col) && $stable(r_row) && $stable(r_row_sum), "counters moved without a beat")
endmodule

// File: hdl/iis_fifo.sv
// Short queue between the front end and the line buffer back end.
module iis_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iis_pkg::t_item i_push_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output iis_pkg::t_item o_head
);
    localparam int PTR_BITS = (iis_pkg::FIFO_DEPTH > 1) ? $clog2(iis_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(iis_pkg::FIFO_DEPTH + 1);

    iis_pkg::t_item        r_mem [iis_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;

    assign o_full  = (r_count == CNT_BITS'(iis_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(iis_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(iis_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: hdl/iis_back.sv
// Back end: line buffer lookup, entry sum, write-back and output register.
`include "integral_image_stream_core_defines.svh"
module iis_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  iis_pkg::t_item                  i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [iis_pkg::SUM_BITS-1:0]    o_area_sum,
    output logic                            o_row_last,
    output logic                            o_plane_last
);
    logic [iis_pkg::SUM_BITS-1:0] r_mem [iis_pkg::MAX_WIDTH];
    logic                         r_b_valid;
    iis_pkg::t_item               r_b_item;
    logic [iis_pkg::SUM_BITS-1:0] r_rd_data;
    logic                         r_fwd_sel;
    logic [iis_pkg::SUM_BITS-1:0] r_fwd_data;
    logic                         r_o_valid;
    logic [iis_pkg::SUM_BITS-1:0] r_o_area_sum;
    logic                         r_o_row_last, r_o_plane_last;
    logic                         w_o_free, w_b_move, w_pop;
    logic [iis_pkg::SUM_BITS-1:0] w_above, w_entry;

    assign w_o_free = !r_o_valid || i_ready;
    assign w_b_move = r_b_valid && w_o_free;
    assign w_pop    = i_head_valid && (!r_b_valid || w_b_move);
    assign o_pop    = w_pop;

    // The line buffer read for the next beat happens on the same edge that
    // writes the current entry, so an equal column takes the fresh sum.
    assign w_above = r_b_item.top_row ? '0 : (r_fwd_sel ? r_fwd_data : r_rd_data);
    assign w_entry = iis_pkg::SUM_BITS'(r_b_item.row_sum) + w_above;

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_mem[r_b_item.col] <= w_entry;
        end
        if (w_pop) begin
            r_rd_data  <= r_mem[i_head.col];
            r_b_item   <= i_head;
            r_fwd_sel  <= w_b_move && (r_b_item.col == i_head.col);
            r_fwd_data <= w_entry;
        end
        if (w_b_move) begin
            r_o_area_sum   <= w_entry;
            r_o_row_last   <= r_b_item.row_last;
            r_o_plane_last <= r_b_item.plane_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_b_valid <= 1'b1;
            end else if (w_b_move) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_area_sum   = r_o_area_sum;
    assign o_row_last   = r_o_row_last;
    assign o_plane_last = r_o_plane_last;

    `IIS_ASSERT(a_b_stall, i_clk, i_rst_n, r_b_valid && !w_o_free |=> r_b_valid && $stable(r_b_item), "lookup stage lost a beat under stall")
    `IIS_ASSERT_NEVER(a_pop_blocked, i_clk, i_rst_n, r_b_valid && !w_o_free && w_pop, "queue popped into a stalled lookup stage")
    `IIS_ASSERT(a_out_load, i_clk, i_rst_n, w_b_move |=> r_o_valid, "finished entry did not reach the output register")
endmodule

// File: hdl/integral_image_stream_core.sv
// Top level of the streaming integral image core.
// Streams 8-bit pixels in raster order, plane after plane, and returns one
// 28-bit integral-image entry per pixel with row and plane end flags. It takes
// one pixel per clock while the output side takes entries; a taken beat passes
// through the queue and the line buffer lookup stage into the output register.
// The rate is set by the single line buffer of 1024 x 28 bits, read at most once
// and written at most once per clock; a two-beat queue lets the input side keep
// taking beats while the output side stalls, until the queue fills. The line
// buffer needs no clearing pass after reset; top rows discard what they read.
module integral_image_stream_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iis_pkg::REG_BITS-1:0]        i_cfg_index,
    input  logic [iis_pkg::SIZE_BITS-1:0]       i_cfg_data,
    input  logic                                i_pix_valid,
    output logic                                o_pix_ready,
    input  logic [iis_pkg::PIXEL_BITS-1:0]      i_pixel,
    output logic                                o_sum_valid,
    input  logic                                i_sum_ready,
    output logic [iis_pkg::SUM_BITS-1:0]        o_area_sum,
    output logic                                o_row_last,
    output logic                                o_plane_last
);
    logic [iis_pkg::SIZE_BITS-1:0] r_image_width, r_image_height;
    logic                          w_push, w_pop, w_full, w_empty;
    iis_pkg::t_item                w_push_item, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= iis_pkg::SIZE_RESET;
            r_image_height <= iis_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iis_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                iis_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    iis_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_valid        (i_pix_valid),
        .i_pixel        (i_pixel),
        .i_queue_full   (w_full),
        .o_ready        (o_pix_ready),
        .o_push         (w_push),
        .o_push_item    (w_push_item)
    );

    iis_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    iis_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_sum_valid),
        .i_ready      (i_sum_ready),
        .o_area_sum   (o_area_sum),
        .o_row_last   (o_row_last),
        .o_plane_last (o_plane_last)
    );
endmodule
